[src/rcfe_pkg.sv]
// ----------------------------------------------------------------------------
// rcfe_pkg
// Shared widths, constants and payload types of the rope chain follow unit.
// ----------------------------------------------------------------------------
package rcfe_pkg;

	localparam int NUM_POINTS = 32;
	localparam int FADE_STEPS = 50;

	localparam int COORD_W  = 32;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int SQ_W     = 2 * DIFF_W;
	localparam int ROOT_W   = SQ_W / 2;
	localparam int SPC_W    = 31;
	localparam int PROD_W   = DIFF_W + SPC_W;
	localparam int LVL_W    = 17;
	localparam int ITER_W   = $clog2(DIFF_W + 1);

	localparam int IDX_W    = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
	localparam int VCNT_W   = $clog2(NUM_POINTS + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = SPC_W;

	localparam logic [LVL_W-1:0] FULL_LEVEL = LVL_W'(65536);
	localparam logic [LVL_W-1:0] ALPHA_STEP = LVL_W'(65536 / NUM_POINTS);

	// floor(c / FADE_STEPS) as (c * FADE_RECIP) >> FADE_SHIFT, exact for c <= 65536
	localparam int FADE_SHIFT = 22;
	localparam int FADE_RW    = FADE_SHIFT + 1;
	localparam logic [FADE_RW-1:0] FADE_RECIP =
		FADE_RW'(((1 << FADE_SHIFT) + FADE_STEPS - 1) / FADE_STEPS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPACING    = 2'd0,
		REG_BASE_RED   = 2'd1,
		REG_BASE_GREEN = 2'd2,
		REG_BASE_BLUE  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] anchor_x;
		logic signed [COORD_W-1:0] anchor_y;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic [LVL_W-1:0]          red;
		logic [LVL_W-1:0]          green;
		logic [LVL_W-1:0]          blue;
		logic [LVL_W-1:0]          alpha;
		logic                      last_vertex;
	} out_item_t;

endpackage

[src/rope_chain_follow_emit_unit.sv]
// ----------------------------------------------------------------------------
// rope_chain_follow_emit_unit
// Follow-the-leader chain: pulls each point to the link length behind its
// predecessor and streams out the anchor plus one faded vertex per point.
// ----------------------------------------------------------------------------
// Each transfer on the input brings an anchor position. The unit walks the
// NUM_POINTS points in order; a point that lies at least spacing from its
// reference (the anchor, or the previous point as it was before this tick) is
// pulled along the line to the spacing. The arithmetic is bit-serial: a
// pair of 33-bit shift-and-add multipliers, a one-digit-per-cycle square root
// and a pair of one-bit-per-cycle dividers. Once every point is done, the
// NUM_POINTS+1 vertices leave at one per cycle while the output side takes
// them. A new anchor is taken once the last vertex of the previous tick sits
// in the output register.
module rope_chain_follow_emit_unit import rcfe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [11:0] {
		S_IDLE    = 12'b0000_0000_0001,
		S_LOAD    = 12'b0000_0000_0010,
		S_SQ_GO   = 12'b0000_0000_0100,
		S_SQ_WAIT = 12'b0000_0000_1000,
		S_RT_GO   = 12'b0000_0001_0000,
		S_RT_WAIT = 12'b0000_0010_0000,
		S_PR_GO   = 12'b0000_0100_0000,
		S_PR_WAIT = 12'b0000_1000_0000,
		S_DV_GO   = 12'b0001_0000_0000,
		S_DV_WAIT = 12'b0010_0000_0000,
		S_STORE   = 12'b0100_0000_0000,
		S_EMIT    = 12'b1000_0000_0000
	} state_t;

	state_t st_q;

	// configuration
	logic [SPC_W-1:0] spacing_q;
	logic [LVL_W-1:0] base_red_q, base_green_q, base_blue_q;

	// chain state
	logic signed [COORD_W-1:0] point_x_q [NUM_POINTS];
	logic signed [COORD_W-1:0] point_y_q [NUM_POINTS];

	logic [IDX_W-1:0]          idx_q;
	logic [VCNT_W-1:0]         vcnt_q;
	logic signed [COORD_W-1:0] anchor_x_q, anchor_y_q;
	logic signed [COORD_W-1:0] ref_x_q, ref_y_q;
	logic signed [COORD_W-1:0] old_x_q, old_y_q;
	logic [DIFF_W-1:0]         mag_x_q, mag_y_q;
	logic                      neg_x_q, neg_y_q;
	logic                      move_q, zero_len_q;

	logic [LVL_W-1:0] col_r_q, col_g_q, col_b_q, alpha_q;
	logic [LVL_W-1:0] fade_r_q, fade_g_q, fade_b_q;

	logic      out_valid_q;
	out_item_t out_q;

	// datapath units
	logic              mul_start, sqrt_start, div_start;
	logic [DIFF_W-1:0] mul_bx, mul_by;
	logic [SQ_W-1:0]   prod_x, prod_y;
	logic              mul_done_x, mul_done_y;
	logic [ROOT_W-1:0] len;
	logic              sqrt_done;
	logic [DIFF_W-1:0] quot_x, quot_y;
	logic              div_done_x, div_done_y;

	logic [IDX_W-1:0]          rd_idx;
	logic [VCNT_W-1:0]         vm1;
	logic signed [COORD_W-1:0] rd_x, rd_y;
	logic signed [DIFF_W-1:0]  dx, dy;
	logic signed [DIFF_W:0]    pull_x, pull_y;
	logic signed [COORD_W-1:0] new_x, new_y;
	logic                      in_xfer, emit_load, emit_last, faded;
	logic [6:0]                pidx;

	function automatic logic [LVL_W-1:0] clamp_lvl(input logic [LVL_W-1:0] v);
		return (v > FULL_LEVEL) ? FULL_LEVEL : v;
	endfunction

	function automatic logic [LVL_W-1:0] fade_of(input logic [LVL_W-1:0] v);
		logic [LVL_W+FADE_RW-1:0] p;
		p = (LVL_W + FADE_RW)'(clamp_lvl(v)) * (LVL_W + FADE_RW)'(FADE_RECIP);
		return LVL_W'(p >> FADE_SHIFT);
	endfunction

	function automatic logic [LVL_W-1:0] sat_sub(input logic [LVL_W-1:0] v,
	                                             input logic [LVL_W-1:0] d);
		return (v >= d) ? (v - d) : '0;
	endfunction

	assign in_ready  = (st_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign emit_load = (st_q == S_EMIT) && (!out_valid_q || out_ready);
	assign emit_last = (vcnt_q == VCNT_W'(NUM_POINTS));
	assign vm1       = vcnt_q - 1'b1;
	assign pidx      = 7'(vm1);
	assign faded     = (pidx >= 7'(FADE_STEPS));

	assign rd_idx = (st_q == S_EMIT) ? vm1[IDX_W-1:0] : idx_q;
	assign rd_x   = point_x_q[rd_idx];
	assign rd_y   = point_y_q[rd_idx];

	assign dx = DIFF_W'(ref_x_q) - DIFF_W'(rd_x);
	assign dy = DIFF_W'(ref_y_q) - DIFF_W'(rd_y);

	// pull toward the point by q: new = ref - q, or ref + q when d is negative
	assign pull_x = neg_x_q ? ((DIFF_W+1)'(ref_x_q) + (DIFF_W+1)'(quot_x))
	                        : ((DIFF_W+1)'(ref_x_q) - (DIFF_W+1)'(quot_x));
	assign pull_y = neg_y_q ? ((DIFF_W+1)'(ref_y_q) + (DIFF_W+1)'(quot_y))
	                        : ((DIFF_W+1)'(ref_y_q) - (DIFF_W+1)'(quot_y));
	assign new_x  = zero_len_q ? ref_x_q : pull_x[COORD_W-1:0];
	assign new_y  = zero_len_q ? ref_y_q : pull_y[COORD_W-1:0];

	assign mul_start  = (st_q == S_SQ_GO) || (st_q == S_PR_GO);
	assign mul_bx     = (st_q == S_PR_GO) ? DIFF_W'(spacing_q) : mag_x_q;
	assign mul_by     = (st_q == S_PR_GO) ? DIFF_W'(spacing_q) : mag_y_q;
	assign sqrt_start = (st_q == S_RT_GO);
	assign div_start  = (st_q == S_DV_GO);

	rcfe_mul u_mul_x (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mag_x_q), .b(mul_bx), .prod(prod_x), .done(mul_done_x)
	);

	rcfe_mul u_mul_y (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mag_y_q), .b(mul_by), .prod(prod_y), .done(mul_done_y)
	);

	rcfe_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start),
		.value(prod_x + prod_y), .root(len), .done(sqrt_done)
	);

	rcfe_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(prod_x[PROD_W-1:0]), .divisor(len),
		.quotient(quot_x), .done(div_done_x)
	);

	rcfe_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(prod_y[PROD_W-1:0]), .divisor(len),
		.quotient(quot_y), .done(div_done_y)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q    <= SPC_W'(655360);
			base_red_q   <= FULL_LEVEL;
			base_green_q <= FULL_LEVEL;
			base_blue_q  <= FULL_LEVEL;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SPACING:    spacing_q    <= cfg_data;
				REG_BASE_RED:   base_red_q   <= cfg_data[LVL_W-1:0];
				REG_BASE_GREEN: base_green_q <= cfg_data[LVL_W-1:0];
				REG_BASE_BLUE:  base_blue_q  <= cfg_data[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and point store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			idx_q       <= '0;
			vcnt_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_POINTS; i++) begin
				point_x_q[i] <= '0;
				point_y_q[i] <= '0;
			end
		end else begin
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (in_xfer) begin
						idx_q <= '0;
						st_q  <= S_LOAD;
					end
				end
				S_LOAD:    st_q <= S_SQ_GO;
				S_SQ_GO:   st_q <= S_SQ_WAIT;
				S_SQ_WAIT: if (mul_done_x) st_q <= S_RT_GO;
				S_RT_GO:   st_q <= S_RT_WAIT;
				S_RT_WAIT: begin
					if (sqrt_done) begin
						// moving with zero length lands on the reference itself
						if (len >= ROOT_W'(spacing_q) && len != '0) begin
							st_q <= S_PR_GO;
						end else begin
							st_q <= S_STORE;
						end
					end
				end
				S_PR_GO:   st_q <= S_PR_WAIT;
				S_PR_WAIT: if (mul_done_x) st_q <= S_DV_GO;
				S_DV_GO:   st_q <= S_DV_WAIT;
				S_DV_WAIT: if (div_done_x) st_q <= S_STORE;
				S_STORE: begin
					if (move_q) begin
						point_x_q[idx_q] <= new_x;
						point_y_q[idx_q] <= new_y;
					end
					if (idx_q == IDX_W'(NUM_POINTS - 1)) begin
						vcnt_q <= '0;
						st_q   <= S_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
						st_q  <= S_LOAD;
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						vcnt_q <= vcnt_q + 1'b1;
						if (emit_last) begin
							st_q <= S_IDLE;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			anchor_x_q <= in_data.anchor_x;
			anchor_y_q <= in_data.anchor_y;
			ref_x_q    <= in_data.anchor_x;
			ref_y_q    <= in_data.anchor_y;
			col_r_q    <= clamp_lvl(base_red_q);
			col_g_q    <= clamp_lvl(base_green_q);
			col_b_q    <= clamp_lvl(base_blue_q);
			fade_r_q   <= fade_of(base_red_q);
			fade_g_q   <= fade_of(base_green_q);
			fade_b_q   <= fade_of(base_blue_q);
			alpha_q    <= FULL_LEVEL;
		end
		if (st_q == S_LOAD) begin
			old_x_q <= rd_x;
			old_y_q <= rd_y;
			neg_x_q <= dx[DIFF_W-1];
			neg_y_q <= dy[DIFF_W-1];
			mag_x_q <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
			mag_y_q <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
		end
		if (st_q == S_RT_WAIT && sqrt_done) begin
			move_q     <= (len >= ROOT_W'(spacing_q));
			zero_len_q <= (len == '0);
		end
		if (st_q == S_STORE) begin
			// next point compares against this one's position before the pull
			ref_x_q <= old_x_q;
			ref_y_q <= old_y_q;
		end
		if (emit_load) begin
			out_q.last_vertex <= emit_last;
			if (vcnt_q == '0) begin
				out_q.vertex_x <= anchor_x_q;
				out_q.vertex_y <= anchor_y_q;
				out_q.red      <= col_r_q;
				out_q.green    <= col_g_q;
				out_q.blue     <= col_b_q;
				out_q.alpha    <= alpha_q;
			end else begin
				out_q.vertex_x <= rd_x;
				out_q.vertex_y <= rd_y;
				out_q.red      <= faded ? '0 : col_r_q;
				out_q.green    <= faded ? '0 : col_g_q;
				out_q.blue     <= faded ? '0 : col_b_q;
				out_q.alpha    <= alpha_q;
				col_r_q        <= sat_sub(col_r_q, fade_r_q);
				col_g_q        <= sat_sub(col_g_q, fade_g_q);
				col_b_q        <= sat_sub(col_b_q, fade_b_q);
				alpha_q        <= sat_sub(alpha_q, ALPHA_STEP);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_pull_len: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_STORE && move_q && !zero_len_q) |-> (len >= ROOT_W'(spacing_q)))
		else $error("point pulled with a length below the spacing");

	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done_x == mul_done_y)
		else $error("multiplier lanes out of step");

	a_div_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(div_done_x || div_done_y) |-> (st_q == S_DV_WAIT))
		else $error("divider finished outside its wait state");
`endif

endmodule

[src/rcfe_mul.sv]
// ----------------------------------------------------------------------------
// rcfe_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rcfe_mul import rcfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIFF_W-1:0] a,
	input  logic [DIFF_W-1:0] b,
	output logic [SQ_W-1:0]   prod,
	output logic              done
);

	logic [SQ_W-1:0]   acc_q;
	logic [SQ_W-1:0]   mc_q;
	logic [DIFF_W-1:0] mp_q;
	logic [ITER_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ITER_W'(DIFF_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= SQ_W'(a);
			mp_q  <= b;
		end else if (busy_q) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= {mc_q[SQ_W-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[DIFF_W-1:1]};
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

[src/rcfe_sqrt.sv]
// ----------------------------------------------------------------------------
// rcfe_sqrt
// Digit-by-digit floor square root, one 2-bit digit of the radicand per cycle.
// ----------------------------------------------------------------------------
module rcfe_sqrt import rcfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   value,
	output logic [ROOT_W-1:0] root,
	output logic              done
);

	logic [SQ_W-1:0]   val_q;
	logic [ROOT_W+2:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ITER_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W+2:0] rem_n;
	logic [ROOT_W+2:0] trial;
	logic              fits;

	assign rem_n = {rem_q[ROOT_W:0], val_q[SQ_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign fits  = (rem_n >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ITER_W'(ROOT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[SQ_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_n - trial) : rem_n;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

[src/rcfe_div.sv]
// ----------------------------------------------------------------------------
// rcfe_div
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit in DIFF_W bits, so only the low dividend bits are shifted through.
// ----------------------------------------------------------------------------
module rcfe_div import rcfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [ROOT_W-1:0] divisor,
	output logic [DIFF_W-1:0] quotient,
	output logic              done
);

	logic [ROOT_W-1:0] rem_q;
	logic [DIFF_W-1:0] dq_q;
	logic [ROOT_W-1:0] dvs_q;
	logic [ITER_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W:0]   trial;
	logic [ROOT_W:0]   diff;
	logic              fits;

	assign trial = {rem_q, dq_q[DIFF_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ITER_W'(DIFF_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient bits shift in where the dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ROOT_W'(dividend[PROD_W-1:DIFF_W]);
			dq_q  <= dividend[DIFF_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
			dq_q  <= {dq_q[DIFF_W-2:0], fits};
		end
	end

	assign quotient = dq_q;
	assign done     = done_q;

endmodule

[tb/sv/rope_chain_follow_emit_unit_tb.sv]
// ----------------------------------------------------------------------------
// rope_chain_follow_emit_unit_tb
// Self-checking bench: anchors go in as valid/ready transfers, every vertex of
// each strip is checked against a local chain model, across several register
// settings, with random gaps on both sides and one long output hold.
// ----------------------------------------------------------------------------
module rope_chain_follow_emit_unit_tb import rcfe_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	rope_chain_follow_emit_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// local copy of the chain and registers
	logic [SPC_W-1:0]          link_len = SPC_W'(655360);
	logic [LVL_W-1:0]          lvl_red = FULL_LEVEL;
	logic [LVL_W-1:0]          lvl_green = FULL_LEVEL;
	logic [LVL_W-1:0]          lvl_blue = FULL_LEVEL;
	logic signed [COORD_W-1:0] chain_x [NUM_POINTS];
	logic signed [COORD_W-1:0] chain_y [NUM_POINTS];

	in_item_t  anchor_q [$];
	out_item_t vertex_q [$];
	int        err_cnt = 0;
	bit        no_idle = 1'b0;
	bit        hold_req = 1'b0;
	bit        hold_seen = 1'b0;
	int        hold_left = 0;
	int        tx_gap = 0;
	int        rx_gap = 0;

	initial begin
		for (int i = 0; i < NUM_POINTS; i++) begin
			chain_x[i] = '0;
			chain_y[i] = '0;
		end
	end

	function automatic logic [32:0] floor_root(logic [65:0] s);
		logic [67:0] rem;
		logic [67:0] trial;
		logic [32:0] root;
		rem = '0;
		root = '0;
		for (int k = 32; k >= 0; k--) begin
			rem = (rem << 2) | 68'((s >> (2 * k)) & 66'd3);
			trial = (68'(root) << 2) | 68'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 33'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic logic signed [COORD_W-1:0] pull_coord(longint ref_c, longint d,
			logic [32:0] m, logic [32:0] len);
		logic [65:0] q;
		if (len == 0)
			return COORD_W'(ref_c);
		q = (66'(m) * 66'(link_len)) / 66'(len);
		if (d < 0)
			return COORD_W'(ref_c + longint'(q));
		return COORD_W'(ref_c - longint'(q));
	endfunction

	function automatic logic [LVL_W-1:0] clamp_lvl(logic [LVL_W-1:0] v);
		return (v > FULL_LEVEL) ? FULL_LEVEL : v;
	endfunction

	// advance the chain by one anchor and queue the whole strip
	function automatic void follow_anchor(in_item_t it);
		longint rx, ry, px, py, dx, dy;
		logic [32:0] mx, my, len;
		logic [65:0] s, lim;
		logic [LVL_W-1:0] cr, cg, cb, fr, fg, fb, a;
		out_item_t v;
		rx = it.anchor_x;
		ry = it.anchor_y;
		lim = 66'(link_len) * 66'(link_len);
		for (int i = 0; i < NUM_POINTS; i++) begin
			px = chain_x[i];
			py = chain_y[i];
			dx = rx - px;
			dy = ry - py;
			mx = 33'((dx < 0) ? -dx : dx);
			my = 33'((dy < 0) ? -dy : dy);
			s = 66'(mx) * 66'(mx) + 66'(my) * 66'(my);
			if (s >= lim) begin
				len = floor_root(s);
				chain_x[i] = pull_coord(rx, dx, mx, len);
				chain_y[i] = pull_coord(ry, dy, my, len);
			end
			rx = px;
			ry = py;
		end
		cr = clamp_lvl(lvl_red);
		cg = clamp_lvl(lvl_green);
		cb = clamp_lvl(lvl_blue);
		fr = cr / FADE_STEPS;
		fg = cg / FADE_STEPS;
		fb = cb / FADE_STEPS;
		a = FULL_LEVEL;
		v = '{it.anchor_x, it.anchor_y, cr, cg, cb, a, 1'b0};
		vertex_q.push_back(v);
		for (int i = 0; i < NUM_POINTS; i++) begin
			v.vertex_x = chain_x[i];
			v.vertex_y = chain_y[i];
			v.alpha = a;
			v.last_vertex = (i == NUM_POINTS - 1);
			if (i < FADE_STEPS) begin
				v.red = cr;
				v.green = cg;
				v.blue = cb;
				cr = (cr >= fr) ? cr - fr : '0;
				cg = (cg >= fg) ? cg - fg : '0;
				cb = (cb >= fb) ? cb - fb : '0;
			end else begin
				v.red = '0;
				v.green = '0;
				v.blue = '0;
			end
			vertex_q.push_back(v);
			a = (a >= ALPHA_STEP) ? a - ALPHA_STEP : '0;
		end
	endfunction

	// anchor driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				follow_anchor(in_data);
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (anchor_q.size() > 0) begin
					in_data <= anchor_q.pop_front();
					in_valid <= 1'b1;
					tx_gap = no_idle ? 0 : $urandom_range(0, 10);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long output hold, counted on its own
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 6000;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// vertex monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (vertex_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected vertex expected none actual %p",
						$time, out_data);
				end else if (vertex_q[0] !== out_data) begin
					err_cnt++;
					$display("%0t: vertex mismatch expected %p actual %p",
						$time, vertex_q[0], out_data);
					void'(vertex_q.pop_front());
				end else begin
					void'(vertex_q.pop_front());
				end
				rx_gap = no_idle ? 0 : $urandom_range(0, 10);
			end else if (rx_gap > 0) begin
				rx_gap--;
			end
			out_ready <= (hold_left == 0) && (rx_gap == 0);
		end
	end

	task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		case (r)
			REG_SPACING:    link_len = v;
			REG_BASE_RED:   lvl_red = v[LVL_W-1:0];
			REG_BASE_GREEN: lvl_green = v[LVL_W-1:0];
			default:        lvl_blue = v[LVL_W-1:0];
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic push_anchor(logic [31:0] x, logic [31:0] y);
		anchor_q.push_back('{x, y});
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (anchor_q.size() != 0 || in_valid || vertex_q.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	// mostly small walks from the last anchor, some full-range jumps
	task automatic random_anchors(int n, int step);
		logic [31:0] x, y;
		x = $urandom;
		y = $urandom;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 4) == 0) begin
				x = $urandom;
				y = $urandom;
			end else begin
				x = x + 32'($signed($urandom_range(0, 2 * step)) - step);
				y = y + 32'($signed($urandom_range(0, 2 * step)) - step);
			end
			push_anchor(x, y);
		end
	endtask

	task automatic random_levels();
		write_reg(REG_BASE_RED, CFG_DATA_W'($urandom_range(0, 65536)));
		write_reg(REG_BASE_GREEN, CFG_DATA_W'($urandom_range(0, 65536)));
		write_reg(REG_BASE_BLUE, CFG_DATA_W'($urandom_range(0, 65536)));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset registers, field extremes, links that stay and move
		@(negedge clk);
		push_anchor(32'h0, 32'h0);
		push_anchor(32'h0004_0000, 32'h0003_0000);
		push_anchor(32'h7fff_ffff, 32'h7fff_ffff);
		push_anchor(32'h8000_0000, 32'h8000_0000);
		push_anchor(32'h7fff_ffff, 32'h8000_0000);
		push_anchor(32'h8000_0000, 32'h7fff_ffff);
		push_anchor(32'hffff_ffff, 32'h0000_0001);
		push_anchor(32'h0000_0001, 32'hffff_ffff);
		push_anchor(32'h0000_0001, 32'hffff_ffff);
		wait_drained();

		// zero link length: the chain collapses, then equal positions pull nowhere
		write_reg(REG_SPACING, '0);
		write_reg(REG_BASE_RED, '0);
		write_reg(REG_BASE_GREEN, CFG_DATA_W'(65536));
		write_reg(REG_BASE_BLUE, CFG_DATA_W'(1));
		@(negedge clk);
		push_anchor(32'h1234_5678, 32'h8765_4321);
		push_anchor(32'h1234_5678, 32'h8765_4321);
		push_anchor(32'h1234_5678, 32'h8765_4321);
		push_anchor(32'h0, 32'hffff_0000);
		wait_drained();

		// longest link; colour above full, with junk in the upper data bits
		write_reg(REG_SPACING, 31'h7fff_ffff);
		write_reg(REG_BASE_RED, {14'h3fff, 17'h1ffff});
		write_reg(REG_BASE_GREEN, {14'h2aaa, 17'h10001});
		write_reg(REG_BASE_BLUE, {14'h1555, 17'd49});
		@(negedge clk);
		push_anchor(32'h7fff_ffff, 32'h7fff_ffff);
		push_anchor(32'h8000_0000, 32'h8000_0000);
		push_anchor(32'h8000_0000, 32'h7fff_ffff);
		push_anchor(32'h0, 32'h0);
		wait_drained();

		// random phases; the first one runs into the long output hold
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_reg(REG_SPACING, 31'h0000_8000);
				1: write_reg(REG_SPACING, 31'h0001_0000);
				2: write_reg(REG_SPACING, 31'(655360));
				3: write_reg(REG_SPACING, 31'($urandom));
				4: write_reg(REG_SPACING, 31'h0);
				default: write_reg(REG_SPACING, 31'($urandom_range(1, 32'h0010_0000)));
			endcase
			random_levels();
			no_idle = (ph == 2);
			@(negedge clk);
			random_anchors(45, (ph == 3) ? 32'h4000_0000 : 32'h0008_0000);
			if (ph == 0) begin
				repeat (20) @(posedge clk);
				hold_req = ~hold_req;
			end
			wait_drained();
		end
		no_idle = 1'b0;

		repeat (60) @(posedge clk);
		if (err_cnt == 0)
			$display("rope_chain_follow_emit_unit_tb passed");
		else
			$display("rope_chain_follow_emit_unit_tb failed");
		$finish;
	end

	initial begin
		#80_000_000;
		$display("rope_chain_follow_emit_unit_tb failed");
		$finish;
	end

endmodule

[sim.f]
src/rcfe_pkg.sv
src/rcfe_mul.sv
src/rcfe_sqrt.sv
src/rcfe_div.sv
src/rope_chain_follow_emit_unit.sv
tb/sv/rope_chain_follow_emit_unit_tb.sv
